[hw/rtl/mvmp_pkg.sv]
// Package for the motion vector median predictor.
// Holds request codes, block numbers and the neighbor status struct.
// No dependencies.
`default_nettype none

package mvmp_pkg;

  localparam logic REQ_STORE   = 1'b0;
  localparam logic REQ_PREDICT = 1'b1;

  localparam logic [1:0] BLK_0 = 2'd0;
  localparam logic [1:0] BLK_1 = 2'd1;
  localparam logic [1:0] BLK_2 = 2'd2;
  localparam logic [1:0] BLK_3 = 2'd3;

  localparam int unsigned CFG_BITS = 8;
  localparam logic [CFG_BITS-1:0] MB_COLUMNS_RESET = 8'd128;

  // Status of one predict request captured next to the RAM read data.
  typedef struct packed {
    logic       first_row;
    logic [1:0] blk;
    logic       ok0;
    logic       ok1;
    logic       ok2a;
    logic       ok2b;
    logic       ok3;
  } nbr_t;

endpackage

`default_nettype wire

[hw/rtl/mvmp_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none

module mvmp_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hw/rtl/mvmp_median.sv]
// Neighbor selection and median of three for one predict request.
// Depends on mvmp_pkg for block numbers and the neighbor status struct.
`default_nettype none

module mvmp_median #(
  parameter int unsigned VECTOR_BITS = 12
) (
  input  wire mvmp_pkg::nbr_t                 nbr_i,
  input  wire logic signed [VECTOR_BITS-1:0]  d0_i,
  input  wire logic signed [VECTOR_BITS-1:0]  d1_i,
  input  wire logic signed [VECTOR_BITS-1:0]  d2a_i,
  input  wire logic signed [VECTOR_BITS-1:0]  d2b_i,
  input  wire logic signed [VECTOR_BITS-1:0]  d3_i,
  output logic signed [VECTOR_BITS-1:0]       pred_o
);

  logic signed [VECTOR_BITS-1:0] m0, m1, m2a, m2b, m3;
  logic signed [VECTOR_BITS-1:0] p1, p2, p3;
  logic signed [VECTOR_BITS-1:0] max_ab, max_bc, max_ac, min_r, med;

  // Neighbors outside the picture or the store read as zero.
  assign m0  = nbr_i.ok0  ? d0_i  : '0;
  assign m1  = nbr_i.ok1  ? d1_i  : '0;
  assign m2a = nbr_i.ok2a ? d2a_i : '0;
  assign m2b = nbr_i.ok2b ? d2b_i : '0;
  assign m3  = nbr_i.ok3  ? d3_i  : '0;

  always_comb begin
    unique case (nbr_i.blk)
      mvmp_pkg::BLK_0: begin
        p1 = m1;
        p2 = m2a;
        p3 = m2b;
      end
      mvmp_pkg::BLK_1: begin
        p1 = m0;
        p2 = m3;
        p3 = m2b;
      end
      mvmp_pkg::BLK_2: begin
        p1 = m3;
        p2 = m0;
        p3 = m1;
      end
      default: begin
        p1 = m2a;
        p2 = m0;
        p3 = m1;
      end
    endcase
  end

  assign max_ab = (p1 > p2) ? p1 : p2;
  assign max_bc = (p2 > p3) ? p2 : p3;
  assign max_ac = (p1 > p3) ? p1 : p3;
  assign min_r  = (max_bc < max_ac) ? max_bc : max_ac;
  assign med    = (max_ab < min_r) ? max_ab : min_r;

  always_comb begin
    priority if (nbr_i.first_row && nbr_i.blk == mvmp_pkg::BLK_0) begin
      pred_o = m1;
    end else if (nbr_i.first_row && nbr_i.blk == mvmp_pkg::BLK_1) begin
      pred_o = m0;
    end else begin
      pred_o = med;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/motion_vector_median_predictor_core.sv]
// Top level of the motion vector median predictor.
// Depends on mvmp_pkg, mvmp_ram and mvmp_median.
`default_nettype none

// The block accepts one request per cycle unless the clearing pass runs or a
// stalled result holds the read stage. A store request writes its vector
// component into the column RAM(s) of its block at the accepting edge and gives
// no result. A predict request reads its neighbors from the column RAMs at the
// accepting edge; its result passes the registered RAM read, then the median
// and result register. After reset the block clears all DEPTH addresses of
// the column RAMs (256 at the default), one address per cycle; no request is
// accepted during that pass, while configuration writes are always accepted.
module motion_vector_median_predictor_core #(
  parameter int unsigned MAX_COLUMNS = 128,
  parameter int unsigned VECTOR_BITS = 12
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [7:0]                    cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          req_type_i,
  input  wire logic [6:0]                    mb_column_i,
  input  wire logic [6:0]                    mb_row_i,
  input  wire logic [1:0]                    block_index_i,
  input  wire logic                          component_i,
  input  wire logic signed [VECTOR_BITS-1:0] vector_value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [VECTOR_BITS-1:0]      predicted_vector_o
);

  localparam int unsigned CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int unsigned AW    = CW + 1;
  localparam int unsigned DEPTH = 2 ** AW;
  localparam logic [8:0]  MAXC  = 9'(MAX_COLUMNS);

  logic [7:0]    mb_columns_q;
  logic          clr_active_q;
  logic [AW-1:0] clr_addr_q;

  logic          in_acc, is_pred, is_store;
  logic          s1_valid_q, s1_adv;
  mvmp_pkg::nbr_t s1_nbr_q, nbr_d;
  logic          out_valid_q;
  logic signed [VECTOR_BITS-1:0] out_data_q, pred;

  logic [8:0]    col_x, col_m1, col_p1;
  logic          ok_x, ok_m1, ok_p1;
  logic [AW-1:0] a_x, a_m1, a_p1, a_ram1, a_ram3;

  logic [3:0]    st_we;
  logic [AW-1:0] w_addr;
  logic [VECTOR_BITS-1:0] w_data;
  logic          we0, we1, we2, we3;

  logic signed [VECTOR_BITS-1:0] d0, d1, d2a, d2b, d3;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mb_columns_q <= mvmp_pkg::MB_COLUMNS_RESET;
    end else if (cfg_valid_i) begin
      mb_columns_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
    end else if (clr_active_q) begin
      clr_addr_q <= clr_addr_q + AW'(1);
      if (clr_addr_q == {AW{1'b1}}) begin
        clr_active_q <= 1'b0;
      end
    end
  end

  assign s1_adv     = !s1_valid_q || !out_valid_q || out_ready_i;
  assign in_ready_o = !clr_active_q && s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;
  assign is_pred    = in_acc && (req_type_i == mvmp_pkg::REQ_PREDICT);
  assign is_store   = in_acc && (req_type_i == mvmp_pkg::REQ_STORE);

  assign col_x  = {2'b00, mb_column_i};
  assign col_m1 = col_x - 9'd1;
  assign col_p1 = col_x + 9'd1;
  assign ok_x   = col_x < MAXC;
  assign ok_m1  = (col_x != 9'd0) && (col_m1 < MAXC);
  assign ok_p1  = (col_p1 < MAXC) && (col_p1 < {1'b0, mb_columns_q});

  assign a_x    = {component_i, col_x[CW-1:0]};
  assign a_m1   = {component_i, col_m1[CW-1:0]};
  assign a_p1   = {component_i, col_p1[CW-1:0]};
  assign a_ram1 = (block_index_i == mvmp_pkg::BLK_0) ? a_m1 : a_x;
  assign a_ram3 = (block_index_i == mvmp_pkg::BLK_2) ? a_m1 : a_x;

  always_comb begin
    nbr_d.first_row = (mb_row_i == 7'd0);
    nbr_d.blk       = block_index_i;
    nbr_d.ok0       = ok_x;
    nbr_d.ok1       = (block_index_i == mvmp_pkg::BLK_0) ? ok_m1 : ok_x;
    nbr_d.ok2a      = ok_x;
    nbr_d.ok2b      = ok_p1;
    nbr_d.ok3       = (block_index_i == mvmp_pkg::BLK_2) ? ok_m1 : ok_x;
  end

  always_comb begin
    unique case (block_index_i)
      mvmp_pkg::BLK_0: st_we = 4'b0001;
      mvmp_pkg::BLK_1: st_we = 4'b0010;
      mvmp_pkg::BLK_2: st_we = 4'b0100;
      default:         st_we = 4'b1000;
    endcase
  end

  assign w_addr = clr_active_q ? clr_addr_q : a_x;
  assign w_data = clr_active_q ? '0 : vector_value_i;
  assign we0    = clr_active_q || (is_store && ok_x && st_we[0]);
  assign we1    = clr_active_q || (is_store && ok_x && st_we[1]);
  assign we2    = clr_active_q || (is_store && ok_x && st_we[2]);
  assign we3    = clr_active_q || (is_store && ok_x && st_we[3]);

  mvmp_ram #(.WIDTH(VECTOR_BITS), .DEPTH(DEPTH)) u_ram0 (
    .clk_i, .we_i(we0), .waddr_i(w_addr), .wdata_i(w_data),
    .re_i(is_pred), .raddr_i(a_x), .rdata_o(d0)
  );

  mvmp_ram #(.WIDTH(VECTOR_BITS), .DEPTH(DEPTH)) u_ram1 (
    .clk_i, .we_i(we1), .waddr_i(w_addr), .wdata_i(w_data),
    .re_i(is_pred), .raddr_i(a_ram1), .rdata_o(d1)
  );

  mvmp_ram #(.WIDTH(VECTOR_BITS), .DEPTH(DEPTH)) u_ram2a (
    .clk_i, .we_i(we2), .waddr_i(w_addr), .wdata_i(w_data),
    .re_i(is_pred), .raddr_i(a_x), .rdata_o(d2a)
  );

  mvmp_ram #(.WIDTH(VECTOR_BITS), .DEPTH(DEPTH)) u_ram2b (
    .clk_i, .we_i(we2), .waddr_i(w_addr), .wdata_i(w_data),
    .re_i(is_pred), .raddr_i(a_p1), .rdata_o(d2b)
  );

  mvmp_ram #(.WIDTH(VECTOR_BITS), .DEPTH(DEPTH)) u_ram3 (
    .clk_i, .we_i(we3), .waddr_i(w_addr), .wdata_i(w_data),
    .re_i(is_pred), .raddr_i(a_ram3), .rdata_o(d3)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_q <= is_pred;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_pred) begin
      s1_nbr_q <= nbr_d;
    end
  end

  mvmp_median #(.VECTOR_BITS(VECTOR_BITS)) u_median (
    .nbr_i(s1_nbr_q), .d0_i(d0), .d1_i(d1), .d2a_i(d2a), .d2b_i(d2b),
    .d3_i(d3), .pred_o(pred)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && (!out_valid_q || out_ready_i)) begin
      out_data_q <= pred;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign predicted_vector_o = out_data_q;

`ifndef SYNTHESIS
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_active_q |-> !in_ready_o)
    else $error("Request accepted during the RAM clearing pass.");

  a_predict_enters_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_pred |=> s1_valid_q)
    else $error("Accepted predict transfer did not reach the read stage.");

  a_s1_holds_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_o && !out_ready_i) |=> s1_valid_q)
    else $error("Read stage lost a result while the output was stalled.");

  a_out_from_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(s1_valid_q))
    else $error("Result appeared without a predict in the read stage.");
`endif

endmodule

`default_nettype wire

[tb/sv/mvmp_prediction_checker.sv]
`timescale 1ns / 100ps
// Result checker for motion_vector_median_predictor_core: keeps its own vector table
// from observed store transfers, predicts each predict result and compares outputs.
// Depends on mvmp_pkg.
module mvmp_prediction_checker
  import mvmp_pkg::*;
#(
  parameter int unsigned MAX_COLUMNS = 128,
  parameter int unsigned VECTOR_BITS = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [CFG_BITS-1:0]           cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic                          req_type_i,
  input  logic [6:0]                    mb_column_i,
  input  logic [6:0]                    mb_row_i,
  input  logic [1:0]                    block_index_i,
  input  logic                          component_i,
  input  logic signed [VECTOR_BITS-1:0] vector_value_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic signed [VECTOR_BITS-1:0] predicted_vector_i,
  output int                            err_count_o,
  output int                            pending_o
);

  typedef logic signed [VECTOR_BITS-1:0] vec_t;

  typedef struct {
    vec_t       vec;
    logic [6:0] col;
    logic [6:0] row;
    logic [1:0] blk;
    logic       comp;
  } pred_t;

  vec_t                mv_table [2][4][MAX_COLUMNS];
  logic [CFG_BITS-1:0] mb_cols;
  pred_t               pred_q [$];
  int                  errors;

  function automatic int table_vec(input logic comp, input logic [1:0] blk, input int col);
    if (col < 0 || col >= int'(MAX_COLUMNS)) return 0;
    return int'(mv_table[comp][blk][col]);
  endfunction

  function automatic int above_right_vec(input logic comp, input logic [1:0] blk,
                                         input int col);
    if (col + 1 >= int'(mb_cols)) return 0;
    return table_vec(comp, blk, col + 1);
  endfunction

  function automatic int median_of3(input int a, input int b, input int c);
    int lo;
    int hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c <= lo) return lo;
    if (c >= hi) return hi;
    return c;
  endfunction

  function automatic vec_t predict_vector(input logic comp, input logic [6:0] col,
                                          input logic [6:0] row, input logic [1:0] blk);
    int x;
    int p0;
    int p1;
    int p2;
    x = int'(col);
    if (row == 7'd0 && blk == BLK_0) return vec_t'(table_vec(comp, BLK_1, x - 1));
    if (row == 7'd0 && blk == BLK_1) return vec_t'(table_vec(comp, BLK_0, x));
    case (blk)
      BLK_0: begin
        p0 = table_vec(comp, BLK_1, x - 1);
        p1 = table_vec(comp, BLK_2, x);
        p2 = above_right_vec(comp, BLK_2, x);
      end
      BLK_1: begin
        p0 = table_vec(comp, BLK_0, x);
        p1 = table_vec(comp, BLK_3, x);
        p2 = above_right_vec(comp, BLK_2, x);
      end
      BLK_2: begin
        p0 = table_vec(comp, BLK_3, x - 1);
        p1 = table_vec(comp, BLK_0, x);
        p2 = table_vec(comp, BLK_1, x);
      end
      default: begin
        p0 = table_vec(comp, BLK_2, x);
        p1 = table_vec(comp, BLK_0, x);
        p2 = table_vec(comp, BLK_1, x);
      end
    endcase
    return vec_t'(median_of3(p0, p1, p2));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    pred_t item;
    if (!rst_ni) begin
      foreach (mv_table[c, b, k]) mv_table[c][b][k] = '0;
      mb_cols = MB_COLUMNS_RESET;
      pred_q.delete();
      errors = 0;
      err_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (pred_q.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("%m: result %0d with no predict request outstanding",
                     predicted_vector_i);
          end
        end else begin
          item = pred_q.pop_front();
          if (predicted_vector_i !== item.vec) begin
            errors++;
            if (errors <= 10) begin
              $display("%m: col %0d row %0d blk %0d comp %0d: expected %0d, got %0d",
                       item.col, item.row, item.blk, item.comp, item.vec,
                       predicted_vector_i);
            end
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) mb_cols = cfg_data_i;
      if (in_valid_i && in_ready_i) begin
        if (req_type_i == REQ_STORE) begin
          if (int'(mb_column_i) < int'(MAX_COLUMNS)) begin
            mv_table[component_i][block_index_i][mb_column_i] = vector_value_i;
          end
        end else begin
          item.vec  = predict_vector(component_i, mb_column_i, mb_row_i, block_index_i);
          item.col  = mb_column_i;
          item.row  = mb_row_i;
          item.blk  = block_index_i;
          item.comp = component_i;
          pred_q.push_back(item);
        end
      end
      err_count_o <= errors;
      pending_o <= pred_q.size();
    end
  end

endmodule

[tb/sv/motion_vector_median_predictor_core_tb.sv]
`timescale 1ns / 100ps
// Testbench top for motion_vector_median_predictor_core: drives requests, width
// writes and result back-pressure, and gives the verdict.
// Depends on mvmp_pkg, the core RTL and mvmp_prediction_checker.
module motion_vector_median_predictor_core_tb;
  import mvmp_pkg::*;

  localparam int unsigned VB = 12;
  localparam int unsigned MAXC = 128;
  localparam int RANDOM_ITEMS = 1350;
  localparam int PHASE_ITEMS = 150;
  localparam int HOLD_CYCLES = 60;
  localparam logic COMP_H = 1'b0;
  localparam logic COMP_V = 1'b1;

  typedef logic signed [VB-1:0] vec_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFG_BITS-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                req_type = REQ_STORE;
  logic [6:0]          mb_column = '0;
  logic [6:0]          mb_row = '0;
  logic [1:0]          block_index = BLK_0;
  logic                component = COMP_H;
  vec_t                vector_value = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  vec_t                predicted_vector;
  int                  err_count;
  int                  pending;
  bit                  no_gaps = 1'b0;
  bit                  hold_request = 1'b0;
  int                  sent_items = 0;

  always #1 clk = ~clk;

  motion_vector_median_predictor_core #(
    .MAX_COLUMNS (MAXC),
    .VECTOR_BITS (VB)
  ) u_top (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .req_type_i         (req_type),
    .mb_column_i        (mb_column),
    .mb_row_i           (mb_row),
    .block_index_i      (block_index),
    .component_i        (component),
    .vector_value_i     (vector_value),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .predicted_vector_o (predicted_vector)
  );

  mvmp_prediction_checker #(
    .MAX_COLUMNS (MAXC),
    .VECTOR_BITS (VB)
  ) u_check (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_i        (cfg_ready),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_ready_i         (in_ready),
    .req_type_i         (req_type),
    .mb_column_i        (mb_column),
    .mb_row_i           (mb_row),
    .block_index_i      (block_index),
    .component_i        (component),
    .vector_value_i     (vector_value),
    .out_valid_i        (out_valid),
    .out_ready_i        (out_ready),
    .predicted_vector_i (predicted_vector),
    .err_count_o        (err_count),
    .pending_o          (pending)
  );

  function automatic int pick_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic vec_t rand_vec();
    case ($urandom_range(0, 7))
      0: return {1'b1, {(VB-1){1'b0}}};
      1: return {1'b0, {(VB-1){1'b1}}};
      2: return vec_t'(int'($urandom_range(0, 16)) - 8);
      default: return vec_t'($urandom());
    endcase
  endfunction

  task automatic send_req(input logic req, input logic [6:0] col, input logic [6:0] row,
                          input logic [1:0] blk, input logic comp, input vec_t val);
    in_valid <= 1'b1;
    req_type <= req;
    mb_column <= col;
    mb_row <= row;
    block_index <= blk;
    component <= comp;
    vector_value <= val;
    do @(posedge clk); while (!in_ready);
    sent_items++;
    if (!no_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
  endtask

  task automatic send_noise();
    send_req($urandom_range(0, 1) ? REQ_PREDICT : REQ_STORE, 7'($urandom_range(0, 127)),
             ($urandom_range(0, 3) == 0) ? 7'd0 : 7'($urandom_range(0, 127)),
             2'($urandom_range(0, 3)), $urandom_range(0, 1) ? COMP_V : COMP_H, rand_vec());
  endtask

  task automatic send_macroblock(input int col, input int row);
    for (int b = 0; b < 4; b++) begin
      for (int c = 0; c < 2; c++) begin
        send_req(REQ_PREDICT, 7'(col), 7'(row), 2'(b), c[0], rand_vec());
        send_req(REQ_STORE, 7'(col), 7'(row), 2'(b), c[0], rand_vec());
      end
    end
  endtask

  task automatic write_width(input int width);
    cfg_valid <= 1'b1;
    cfg_data <= 8'(width);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin : timeout_guard
    #2000000;
    $display("motion_vector_median_predictor_core_tb: done, errors");
    $finish;
  end

  // The receiver stalls at random, and on request holds off for a long stretch.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        stall_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (!no_gaps && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap() - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int width;
    int col_at;
    int row_at;
    int phase_end;
    int target;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_req(REQ_PREDICT, 7'd0, 7'd0, BLK_0, COMP_H, '0);
    send_req(REQ_STORE, 7'd0, 7'd0, BLK_1, COMP_H, 12'sd2047);
    send_req(REQ_STORE, 7'd5, 7'd0, BLK_1, COMP_H, -12'sd2048);
    send_req(REQ_PREDICT, 7'd1, 7'd0, BLK_0, COMP_H, '0);
    send_req(REQ_PREDICT, 7'd6, 7'd0, BLK_0, COMP_H, '0);
    send_req(REQ_STORE, 7'd127, 7'd0, BLK_0, COMP_V, -12'sd2048);
    send_req(REQ_PREDICT, 7'd127, 7'd0, BLK_1, COMP_V, 12'sd2047);
    send_req(REQ_STORE, 7'd0, 7'd1, BLK_2, COMP_H, 12'sd100);
    send_req(REQ_STORE, 7'd1, 7'd1, BLK_2, COMP_H, -12'sd5);
    send_req(REQ_PREDICT, 7'd0, 7'd1, BLK_0, COMP_H, '0);
    send_req(REQ_STORE, 7'd126, 7'd127, BLK_1, COMP_H, 12'sd7);
    send_req(REQ_STORE, 7'd127, 7'd127, BLK_2, COMP_H, 12'sd9);
    send_req(REQ_PREDICT, 7'd127, 7'd127, BLK_0, COMP_H, '0);
    send_req(REQ_STORE, 7'd0, 7'd3, BLK_3, COMP_H, -12'sd300);
    send_req(REQ_PREDICT, 7'd0, 7'd3, BLK_1, COMP_H, '0);
    send_req(REQ_PREDICT, 7'd1, 7'd2, BLK_2, COMP_H, '0);
    send_req(REQ_PREDICT, 7'd0, 7'd2, BLK_3, COMP_H, '0);
    send_req(REQ_STORE, 7'd3, 7'd77, BLK_0, COMP_V, 12'sd1234);
    send_req(REQ_PREDICT, 7'd3, 7'd0, BLK_1, COMP_V, '0);
    send_req(REQ_PREDICT, 7'd3, 7'd64, BLK_3, COMP_V, '0);
    drain();
    write_width(1);
    send_req(REQ_PREDICT, 7'd0, 7'd5, BLK_0, COMP_H, '0);
    send_req(REQ_PREDICT, 7'd0, 7'd5, BLK_1, COMP_H, '0);
    send_req(REQ_PREDICT, 7'd5, 7'd9, BLK_0, COMP_H, '0);
    drain();

    // Back-to-back predicts against a long receiver hold fill the pipeline.
    no_gaps = 1'b1;
    hold_request = 1'b1;
    repeat (24) begin
      send_req(REQ_PREDICT, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
               2'($urandom_range(0, 3)), $urandom_range(0, 1) ? COMP_V : COMP_H, rand_vec());
    end
    no_gaps = 1'b0;
    drain();

    target = sent_items + RANDOM_ITEMS;
    for (int ph = 0; sent_items < target; ph++) begin
      drain();
      if (ph == 0) width = MAXC;
      else if (ph == 1) width = 1;
      else if ($urandom_range(0, 4) == 0) width = MAXC;
      else width = $urandom_range(2, 8);
      write_width(width);
      no_gaps = (ph % 4 == 3);
      col_at = $urandom_range(0, width - 1);
      row_at = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 127);
      phase_end = sent_items + PHASE_ITEMS;
      while (sent_items < phase_end) begin
        if ($urandom_range(0, 99) < 15) begin
          send_noise();
        end else begin
          send_macroblock(col_at, row_at);
          col_at++;
          if (col_at >= width) begin
            col_at = 0;
            row_at = (row_at + 1) % 128;
          end
        end
      end
    end
    no_gaps = 1'b0;
    drain();

    if (err_count == 0 && pending == 0) begin
      $display("motion_vector_median_predictor_core_tb: done, clean");
    end else begin
      $display("motion_vector_median_predictor_core_tb: done, errors");
    end
    $finish;
  end

endmodule
